[rtl/rfpm_pkg.sv]
// ----------------------------------------------------------------------------
// rfpm_pkg
// Shared types and constants of the ring buffer pointer manager.
// ----------------------------------------------------------------------------
package rfpm_pkg;

  localparam int MAX_BURST = 64;

  localparam int AW   = 32;  // byte address
  localparam int BW   = 25;  // buffer length
  localparam int EW   = 13;  // entry length
  localparam int SW   = 17;  // stride length
  localparam int OW   = 24;  // stored offset, reduced below the buffer length by each checked request
  localparam int NW   = 7;   // entry count
  localparam int SLW  = 16;  // slot index
  localparam int LW   = 22;  // entries left
  localparam int SOW  = 13;  // slot out
  localparam int PW   = 14;  // entries per stride
  localparam int CIW  = 2;   // config index

  localparam logic [2:0] ACT_ENABLE  = 3'd0;
  localparam logic [2:0] ACT_DISABLE = 3'd1;
  localparam logic [2:0] ACT_WRITE   = 3'd2;
  localparam logic [2:0] ACT_COMMIT  = 3'd3;
  localparam logic [2:0] ACT_READ    = 3'd4;

  localparam logic [CIW-1:0] CFG_BASE   = 2'd0;
  localparam logic [CIW-1:0] CFG_BUFFER = 2'd1;
  localparam logic [CIW-1:0] CFG_ENTRY  = 2'd2;
  localparam logic [CIW-1:0] CFG_STRIDE = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_OFF   = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef enum logic [2:0] {
    OP_ENABLE,
    OP_DISABLE,
    OP_WRITE,
    OP_COMMIT,
    OP_READ,
    OP_BAD
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            cnt_bad;
    logic [NW-1:0]   n;
    logic [SLW-1:0]  slot;
  } cmd_t;

  typedef struct packed {
    logic [AW-1:0]  base;
    logic [BW-1:0]  buf_len;
    logic [EW-1:0]  ent;
    logic [SW-1:0]  stride;
  } cfg_t;

  typedef struct packed {
    logic [AW-1:0]   addr;
    logic            last;
    logic [1:0]      status;
    logic            rd;
    logic [LW-1:0]   left;
    logic [SOW-1:0]  slot;
    logic            sv;
    logic            ovf;
  } res_t;

endpackage

[rtl/ring_fifo_pointer_manager.sv]
// ----------------------------------------------------------------------------
// ring_fifo_pointer_manager
// Read/write pointer manager of one drop-oldest ring buffer in memory.
//
//   channel  dir  handshake               word
//   in       in   in_valid_i/in_ready_o   action, entry_count, slot_index
//   out      out  out_valid_o/out_ready_i mem_address .. overflowed
//   cfg      in   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One request at a time in the back end; a two-word queue takes input unless full.
// A checked request runs up to 5 divides on the shared serial divider (fewer when
// a check fails), plus up to 3 more (read), 2 (commit) or 1 (write); a write
// then emits one address per cycle while the output register is not stalled.
// Simple answers skip the divider. Reset clears pointers, enable, overflow count.
// The output register stalls the sequencer only while out_ready_i is low.
// ----------------------------------------------------------------------------
module ring_fifo_pointer_manager (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rfpm_pkg::CIW-1:0]  cfg_idx_i,
  input  logic [rfpm_pkg::AW-1:0]   cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                action_i,
  input  logic [rfpm_pkg::NW-1:0]   entry_count_i,
  input  logic [rfpm_pkg::SLW-1:0]  slot_index_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rfpm_pkg::AW-1:0]   mem_address_o,
  output logic                      last_o,
  output logic [1:0]                status_o,
  output logic                      entry_read_o,
  output logic [rfpm_pkg::LW-1:0]   entries_left_o,
  output logic [rfpm_pkg::SOW-1:0]  slot_out_o,
  output logic                      slot_valid_o,
  output logic                      overflowed_o
);

  rfpm_pkg::cfg_t cfg_q, cfg_d;
  logic           q_valid, q_pop;
  rfpm_pkg::cmd_t q_cmd;
  rfpm_pkg::res_t res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rfpm_pkg::CFG_BASE:   cfg_d.base    = cfg_wdata_i;
        rfpm_pkg::CFG_BUFFER: cfg_d.buf_len = cfg_wdata_i[rfpm_pkg::BW-1:0];
        rfpm_pkg::CFG_ENTRY:  cfg_d.ent     = cfg_wdata_i[rfpm_pkg::EW-1:0];
        rfpm_pkg::CFG_STRIDE: cfg_d.stride  = cfg_wdata_i[rfpm_pkg::SW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base    <= '0;
      cfg_q.buf_len <= 25'd4096;
      cfg_q.ent     <= 13'd8;
      cfg_q.stride  <= 17'd8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rfpm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .entry_count_i (entry_count_i),
    .slot_index_i  (slot_index_i),
    .q_valid_o     (q_valid),
    .q_cmd_o       (q_cmd),
    .q_pop_i       (q_pop)
  );

  rfpm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign mem_address_o  = res.addr;
  assign last_o         = res.last;
  assign status_o       = res.status;
  assign entry_read_o   = res.rd;
  assign entries_left_o = res.left;
  assign slot_out_o     = res.slot;
  assign slot_valid_o   = res.sv;
  assign overflowed_o   = res.ovf;

endmodule

[rtl/rfpm_front.sv]
// ----------------------------------------------------------------------------
// rfpm_front
// Accepts request words, decodes the action and queues them for the back end.
// ----------------------------------------------------------------------------
module rfpm_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              action_i,
  input  logic [rfpm_pkg::NW-1:0] entry_count_i,
  input  logic [rfpm_pkg::SLW-1:0] slot_index_i,
  output logic                    q_valid_o,
  output rfpm_pkg::cmd_t          q_cmd_o,
  input  logic                    q_pop_i
);

  rfpm_pkg::cmd_t mem_q [2];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  rfpm_pkg::cmd_t cmd;
  logic           push;

  always_comb begin
    cmd.n       = entry_count_i;
    cmd.slot    = slot_index_i;
    cmd.cnt_bad = (entry_count_i == '0) ||
                  (entry_count_i > rfpm_pkg::NW'(rfpm_pkg::MAX_BURST));
    case (action_i)
      rfpm_pkg::ACT_ENABLE:  cmd.op = rfpm_pkg::OP_ENABLE;
      rfpm_pkg::ACT_DISABLE: cmd.op = rfpm_pkg::OP_DISABLE;
      rfpm_pkg::ACT_WRITE:   cmd.op = rfpm_pkg::OP_WRITE;
      rfpm_pkg::ACT_COMMIT:  cmd.op = rfpm_pkg::OP_COMMIT;
      rfpm_pkg::ACT_READ:    cmd.op = rfpm_pkg::OP_READ;
      default:               cmd.op = rfpm_pkg::OP_BAD;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = q_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd;
    end
  end

endmodule

[rtl/rfpm_div.sv]
// ----------------------------------------------------------------------------
// rfpm_div
// Restoring divider, one quotient bit per cycle; results hold until restart.
// ----------------------------------------------------------------------------
module rfpm_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [rfpm_pkg::AW-1:0] num_i,
  input  logic [rfpm_pkg::BW-1:0] den_i,
  output logic                    done_o,
  output logic [rfpm_pkg::AW-1:0] quo_o,
  output logic [rfpm_pkg::BW-1:0] rem_o
);

  logic [rfpm_pkg::AW-1:0] quo_q, quo_d;
  logic [rfpm_pkg::BW:0]   rem_q, rem_d;
  logic [rfpm_pkg::BW-1:0] den_q, den_d;
  logic [5:0]              cnt_q, cnt_d;
  logic                    busy_q, busy_d, done_q, done_d;
  logic [rfpm_pkg::BW:0]   sh;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sh     = {rem_q[rfpm_pkg::BW-1:0], quo_q[rfpm_pkg::AW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[rfpm_pkg::AW-2:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[rfpm_pkg::AW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(rfpm_pkg::AW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[rfpm_pkg::BW-1:0];

endmodule

[rtl/rfpm_back.sv]
// ----------------------------------------------------------------------------
// rfpm_back
// Pointer state and sequencer: runs queued requests and emits result words.
// ----------------------------------------------------------------------------
module rfpm_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rfpm_pkg::cfg_t          cfg_i,
  input  logic                    q_valid_i,
  input  rfpm_pkg::cmd_t          q_cmd_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output rfpm_pkg::res_t          out_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV, ST_CFG, ST_PER, ST_RR, ST_RW, ST_RL, ST_ACT, ST_START,
    ST_LIN, ST_COM, ST_COM2, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_OUT, ST_EMIT
  } st_e;

  st_e                      st_q, st_d, ret_q, ret_d;
  rfpm_pkg::cmd_t           cmd_q, cmd_d;
  logic [rfpm_pkg::OW-1:0]  r_q, r_d, w_q, w_d, l_q, l_d, cur_q, cur_d;
  logic                     lv_q, lv_d, on_q, on_d, ovf_q, ovf_d;
  logic [31:0]              ovt_q, ovt_d;
  logic [rfpm_pkg::PW-1:0]  per_q, per_d;
  logic [rfpm_pkg::NW-1:0]  cnt_q, cnt_d;
  rfpm_pkg::res_t           res_q, res_d, out_q, out_d;
  logic                     ovalid_q, ovalid_d;

  logic                     div_start, div_done;
  logic [rfpm_pkg::AW-1:0]  div_num, div_quo;
  logic [rfpm_pkg::BW-1:0]  div_den, div_rem;

  logic                     out_free, cfg_ok, is_last;
  logic [rfpm_pkg::BW-1:0]  b, e25, space, step, rn, span, nwe;
  logic [rfpm_pkg::BW-1:0]  w25, r25, l25, cur25;
  logic [28:0]              slot_bytes;
  logic [19:0]              lin_bytes;
  logic [rfpm_pkg::SW-1:0]  slot_end;

  rfpm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  always_comb begin
    b     = cfg_i.buf_len;
    e25   = rfpm_pkg::BW'(cfg_i.ent);
    w25   = rfpm_pkg::BW'(w_q);
    r25   = rfpm_pkg::BW'(r_q);
    l25   = rfpm_pkg::BW'(l_q);
    cur25 = rfpm_pkg::BW'(cur_q);
    cfg_ok = (cfg_i.ent >= 13'd8) && (cfg_i.ent <= 13'd4096) && (cfg_i.ent[2:0] == 3'd0) &&
             (b >= e25) && (b <= 25'd16777216) &&
             (cfg_i.stride >= 17'd8) && (cfg_i.stride <= 17'd65536);
    space = (r_q > w_q) ? (r25 - w25) : (b - (w25 - r25));
    slot_bytes = 29'(cfg_i.ent) * 29'(cmd_q.slot);
    lin_bytes  = 20'(cfg_i.ent) * 20'(cmd_q.n);
    slot_end   = rfpm_pkg::SW'(cmd_q.slot) + rfpm_pkg::SW'(cmd_q.n);
    rn   = r25 + e25;
    if (rn >= b) rn = rn - b;
    step = cur25 + e25;
    if (step >= b) step = step - b;
    nwe  = div_rem + e25;
    if (nwe >= b) nwe = nwe - b;
    span = (l25 >= r25) ? (l25 - r25) : (b - r25 + l25);
    is_last = (cnt_q == cmd_q.n - 7'd1);
  end

  always_comb begin
    st_d     = st_q;
    ret_d    = ret_q;
    cmd_d    = cmd_q;
    r_d      = r_q;
    w_d      = w_q;
    l_d      = l_q;
    cur_d    = cur_q;
    lv_d     = lv_q;
    on_d     = on_q;
    ovf_d    = ovf_q;
    ovt_d    = ovt_q;
    per_d    = per_q;
    cnt_d    = cnt_q;
    res_d    = res_q;
    out_d    = out_q;
    ovalid_d = ovalid_q;
    q_pop_o  = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = b;
    out_free  = !ovalid_q || out_ready_i;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o    = 1'b1;
          cmd_d      = q_cmd_i;
          res_d      = '0;
          res_d.last = 1'b1;
          st_d       = ST_OUT;
          case (q_cmd_i.op)
            rfpm_pkg::OP_ENABLE: begin
              if (!on_q) begin
                r_d  = w_q;
                lv_d = 1'b0;
              end
              on_d = 1'b1;
            end
            rfpm_pkg::OP_DISABLE: on_d = 1'b0;
            rfpm_pkg::OP_BAD: res_d.status = rfpm_pkg::STAT_RANGE;
            default: begin
              if (q_cmd_i.op != rfpm_pkg::OP_COMMIT && !on_q) begin
                res_d.status = rfpm_pkg::STAT_OFF;
              end else if (!cfg_ok) begin
                res_d.status = rfpm_pkg::STAT_RANGE;
              end else begin
                div_start = 1'b1;
                div_num   = rfpm_pkg::AW'(b);
                div_den   = e25;
                ret_d     = ST_CFG;
                st_d      = ST_DIV;
              end
            end
          endcase
        end
      end
      ST_DIV: if (div_done) st_d = ret_q;
      ST_CFG: begin
        if (div_rem != '0) begin
          res_d.status = rfpm_pkg::STAT_RANGE;
          st_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = rfpm_pkg::AW'(cfg_i.stride);
          div_den   = e25;
          ret_d     = ST_PER;
          st_d      = ST_DIV;
        end
      end
      ST_PER: begin
        per_d     = div_quo[rfpm_pkg::PW-1:0];
        div_start = 1'b1;
        div_num   = rfpm_pkg::AW'(r_q);
        ret_d     = ST_RR;
        st_d      = ST_DIV;
      end
      ST_RR: begin
        r_d       = div_rem[rfpm_pkg::OW-1:0];
        div_start = 1'b1;
        div_num   = rfpm_pkg::AW'(w_q);
        ret_d     = ST_RW;
        st_d      = ST_DIV;
      end
      ST_RW: begin
        w_d       = div_rem[rfpm_pkg::OW-1:0];
        div_start = 1'b1;
        div_num   = rfpm_pkg::AW'(l_q);
        ret_d     = ST_RL;
        st_d      = ST_DIV;
      end
      ST_RL: begin
        l_d  = div_rem[rfpm_pkg::OW-1:0];
        st_d = ST_ACT;
      end
      ST_ACT: begin
        st_d = ST_DIV;
        case (cmd_q.op)
          rfpm_pkg::OP_WRITE: begin
            cnt_d = '0;
            if (cmd_q.cnt_bad) begin
              res_d.status = rfpm_pkg::STAT_RANGE;
              st_d = ST_OUT;
            end else if (per_q > 14'd1) begin
              if (slot_end > rfpm_pkg::SW'(per_q)) begin
                res_d.status = rfpm_pkg::STAT_RANGE;
                st_d = ST_OUT;
              end else begin
                ovf_d     = 1'b0;
                div_start = 1'b1;
                div_num   = rfpm_pkg::AW'(w_q) + rfpm_pkg::AW'(slot_bytes);
                ret_d     = ST_START;
              end
            end else begin
              ovf_d     = (rfpm_pkg::BW'(lin_bytes) >= space);
              cur_d     = w_q;
              div_start = 1'b1;
              div_num   = rfpm_pkg::AW'(w_q) + rfpm_pkg::AW'(lin_bytes);
              ret_d     = ST_LIN;
            end
          end
          rfpm_pkg::OP_COMMIT: begin
            ovf_d     = (rfpm_pkg::BW'(cfg_i.stride) >= space);
            div_start = 1'b1;
            div_num   = rfpm_pkg::AW'(w_q) + rfpm_pkg::AW'(cfg_i.stride);
            ret_d     = ST_COM;
          end
          rfpm_pkg::OP_READ: begin
            if (r_q == w_q) begin
              res_d.status = rfpm_pkg::STAT_EMPTY;
              st_d = ST_OUT;
            end else begin
              cur_d     = r_q;
              l_d       = lv_q ? l_q : w_q;
              lv_d      = (rn != w25);
              r_d       = rn[rfpm_pkg::OW-1:0];
              div_start = 1'b1;
              div_num   = rfpm_pkg::AW'(r_q);
              div_den   = e25;
              ret_d     = ST_RD1;
            end
          end
          default: begin
            res_d.status = rfpm_pkg::STAT_RANGE;
            st_d = ST_OUT;
          end
        endcase
      end
      ST_START: begin
        cur_d = div_rem[rfpm_pkg::OW-1:0];
        st_d  = ST_EMIT;
      end
      ST_LIN: begin
        w_d = div_rem[rfpm_pkg::OW-1:0];
        if (ovf_q) begin
          r_d   = nwe[rfpm_pkg::OW-1:0];
          ovt_d = ovt_q + 32'd1;
        end
        st_d = ST_EMIT;
      end
      ST_COM: begin
        w_d        = div_rem[rfpm_pkg::OW-1:0];
        res_d.addr = cfg_i.base + rfpm_pkg::AW'(div_rem);
        res_d.ovf  = ovf_q;
        if (ovf_q) begin
          ovt_d     = ovt_q + 32'd1;
          div_start = 1'b1;
          div_num   = rfpm_pkg::AW'(div_rem) + rfpm_pkg::AW'(cfg_i.stride);
          ret_d     = ST_COM2;
          st_d      = ST_DIV;
        end else begin
          st_d = ST_OUT;
        end
      end
      ST_COM2: begin
        r_d  = div_rem[rfpm_pkg::OW-1:0];
        st_d = ST_OUT;
      end
      ST_RD1: begin
        res_d.rd   = 1'b1;
        res_d.addr = cfg_i.base + rfpm_pkg::AW'(cur_q);
        if (per_q > 14'd1) begin
          res_d.sv  = 1'b1;
          div_start = 1'b1;
          div_num   = div_quo;
          div_den   = rfpm_pkg::BW'(per_q);
          ret_d     = ST_RD2;
          st_d      = ST_DIV;
        end else begin
          st_d = ST_RD3;
        end
      end
      ST_RD2: begin
        res_d.slot = div_rem[rfpm_pkg::SOW-1:0];
        st_d       = ST_RD3;
      end
      ST_RD3: begin
        if (lv_q) begin
          div_start = 1'b1;
          div_num   = rfpm_pkg::AW'(span);
          div_den   = e25;
          ret_d     = ST_RD4;
          st_d      = ST_DIV;
        end else begin
          st_d = ST_OUT;
        end
      end
      ST_RD4: begin
        res_d.left = div_quo[rfpm_pkg::LW-1:0];
        st_d       = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          out_d    = res_q;
          st_d     = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          out_d     = '0;
          out_d.addr = cfg_i.base + rfpm_pkg::AW'(cur_q);
          out_d.last = is_last;
          out_d.ovf  = ovf_q;
          cur_d     = step[rfpm_pkg::OW-1:0];
          cnt_d     = cnt_q + 7'd1;
          if (is_last) st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      ret_q    <= ST_IDLE;
      r_q      <= '0;
      w_q      <= '0;
      l_q      <= '0;
      lv_q     <= 1'b0;
      on_q     <= 1'b0;
      ovt_q    <= '0;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      st_q     <= st_d;
      ret_q    <= ret_d;
      r_q      <= r_d;
      w_q      <= w_d;
      l_q      <= l_d;
      lv_q     <= lv_d;
      on_q     <= on_d;
      ovt_q    <= ovt_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    cur_q <= cur_d;
    ovf_q <= ovf_d;
    per_q <= per_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_o       = out_q;

endmodule
